/* hdl/route_length_accumulator_macros.svh */
// ----------------------------------------------------------------------------
// Route length accumulator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, idle in reset.
// ----------------------------------------------------------------------------
`ifndef ROUTE_LENGTH_ACCUMULATOR_MACROS_SVH
`define ROUTE_LENGTH_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define RLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rla_pkg.sv */
// ----------------------------------------------------------------------------
// Route length accumulator package
// Field widths, request and result types, and mode codes.
// ----------------------------------------------------------------------------
package rla_pkg;

  localparam int CoordW = 24;          // coordinate width, 8 fraction bits
  localparam int IdxW   = 10;          // point index width
  localparam int CountW = 11;          // point_count register width
  localparam int LenW   = 40;          // accumulated length width
  localparam int MagW   = CoordW;      // |dx|, |dy| fit the coordinate width
  localparam int LegW   = CoordW + 1;  // root of a (2*CoordW+1)-bit sum

  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  // request modes
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeStep = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [IdxW-1:0]          point_index;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic                     last_step;
  } req_t;

  typedef struct packed {
    logic [LenW-1:0] route_length;
    logic            index_error;
    logic            length_saturated;
  } rsp_t;

endpackage

/* hdl/rla_leg.sv */
// ----------------------------------------------------------------------------
// Route length accumulator leg unit
// Squares |dx| and |dy| on one shared multiplier, adds them, then takes the
// floored square root one result bit per cycle.
// ----------------------------------------------------------------------------
module rla_leg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rla_pkg::MagW-1:0]  ax_i,
  input  logic [rla_pkg::MagW-1:0]  ay_i,
  output logic                      done_o,
  output logic [rla_pkg::LegW-1:0]  leg_o
);

  localparam int K    = rla_pkg::LegW;   // root bits = iterations
  localparam int RadW = 2 * K;           // radicand padded to whole digit pairs
  localparam int SqW  = 2 * rla_pkg::MagW;
  localparam int CntW = $clog2(K);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_SQX  = 3'd1;
  localparam logic [2:0] U_SQY  = 3'd2;
  localparam logic [2:0] U_SUM  = 3'd3;
  localparam logic [2:0] U_ROOT = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [rla_pkg::MagW-1:0] ax_q, ay_q;
  logic [SqW-1:0]           sq_q;
  logic [RadW-1:0]          rad_q;
  logic [K-1:0]             rem_q;
  logic [K-1:0]             root_q;
  logic [CntW-1:0]          cnt_q;
  logic                     done_q;

  logic [rla_pkg::MagW-1:0] mul_op;
  logic [SqW-1:0]           prod;
  logic [K+1:0]             rem_sh;
  logic [K+1:0]             trial;
  logic                     fits;

  // shared squarer
  assign mul_op = (state_q == U_SQX) ? ax_q : ay_q;
  assign prod   = mul_op * mul_op;

  // one root digit: bring down two radicand bits, try (root << 2) | 1
  assign rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE: if (start_i) state_d = U_SQX;
      U_SQX:  state_d = U_SQY;
      U_SQY:  state_d = U_SUM;
      U_SUM:  state_d = U_ROOT;
      U_ROOT: if (cnt_q == '0) state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == U_ROOT) && (cnt_q == '0);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          ax_q <= ax_i;
          ay_q <= ay_i;
        end
      end
      U_SQX: rad_q <= RadW'(prod);
      U_SQY: sq_q  <= prod;
      U_SUM: begin
        rad_q  <= rad_q + RadW'(sq_q);
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= CntW'(K - 1);
      end
      U_ROOT: begin
        rem_q  <= fits ? K'(rem_sh - trial) : K'(rem_sh);
        root_q <= {root_q[K-2:0], fits};
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        cnt_q  <= cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign leg_o  = root_q;

endmodule

/* hdl/route_length_accumulator.sv */
// ----------------------------------------------------------------------------
// Route length accumulator
// Loads points into a coordinate store, then sums the Euclidean leg lengths
// of a route through them into a saturating 40-bit total.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  request   in         start / busy            req_i  (rla_pkg::req_t)
//  result    out        rsp_valid_o strobe      rsp_o  (rla_pkg::rsp_t)
//  config    in         cfg_valid_i/cfg_ready_o cfg_data_i (point_count)
//
//  A load request leaves busy low.
//  A route step without a leg passes through S_LOOK; a step with a leg also
//  waits in S_WAIT for the bit-serial root.
//  The result strobe is high for one cycle, the cycle after the last step
//  finishes, and the receiver cannot stall it.
//  Reset clears the route state and point_count; the store is not cleared.
// ----------------------------------------------------------------------------
module route_length_accumulator #(
  parameter int POINT_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  rla_pkg::req_t                req_i,
  output logic                         rsp_valid_o,
  output rla_pkg::rsp_t                rsp_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rla_pkg::CountW-1:0]   cfg_data_i
);

  localparam int AW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
  localparam int CW = rla_pkg::CoordW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [rla_pkg::CountW-1:0]  count_q;
  logic                        bad_q, last_q;
  logic [2*CW-1:0]             rd_q;
  logic [2*CW-1:0]             mem [POINT_DEPTH];

  logic                        started_q, started_d;
  logic                        err_q, err_d;
  logic                        clip_q, clip_d;
  logic [rla_pkg::LenW-1:0]    sum_q, sum_d;
  logic signed [CW-1:0]        prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic                        rsp_valid_q, rsp_valid_d;
  rla_pkg::rsp_t               rsp_q, rsp_d;

  logic                        acc;
  logic                        in_depth;
  logic                        bad;
  logic [AW-1:0]               addr;
  logic signed [CW-1:0]        cur_x, cur_y;
  logic signed [CW:0]          dx, dy;
  logic [rla_pkg::MagW-1:0]    ax, ay;
  logic                        leg_start, leg_done;
  logic [rla_pkg::LegW-1:0]    leg;
  logic [rla_pkg::LenW:0]      sum_ext;
  logic                        emit;

  // request decode
  assign acc      = start && !busy;
  assign addr     = AW'(req_i.point_index);
  assign in_depth = (32'(req_i.point_index) < POINT_DEPTH);
  assign bad      = ({1'b0, req_i.point_index} >= count_q) || !in_depth;

  // coordinate store, registered read
  always_ff @(posedge clk_i) begin
    if (acc && req_i.mode == rla_pkg::ModeLoad && in_depth) begin
      mem[addr] <= {req_i.coord_x, req_i.coord_y};
    end
    if (acc && req_i.mode == rla_pkg::ModeStep) begin
      rd_q   <= mem[addr];
      bad_q  <= bad;
      last_q <= req_i.last_step;
    end
  end

  // point of this step; an out-of-range index reads as the origin
  assign cur_x = bad_q ? '0 : $signed(rd_q[2*CW-1:CW]);
  assign cur_y = bad_q ? '0 : $signed(rd_q[CW-1:0]);
  assign dx    = {cur_x[CW-1], cur_x} - {prev_x_q[CW-1], prev_x_q};
  assign dy    = {cur_y[CW-1], cur_y} - {prev_y_q[CW-1], prev_y_q};
  assign ax    = rla_pkg::MagW'(dx[CW] ? -dx : dx);
  assign ay    = rla_pkg::MagW'(dy[CW] ? -dy : dy);

  rla_leg u_leg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (leg_start),
    .ax_i    (ax),
    .ay_i    (ay),
    .done_o  (leg_done),
    .leg_o   (leg)
  );

  assign sum_ext = {1'b0, sum_q} + (rla_pkg::LenW + 1)'(leg);

  // step sequencer and route state
  always_comb begin
    state_d     = state_q;
    started_d   = started_q;
    err_d       = err_q;
    clip_d      = clip_q;
    sum_d       = sum_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    leg_start   = 1'b0;
    emit        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (acc && req_i.mode == rla_pkg::ModeStep) state_d = S_LOOK;
      end
      S_LOOK: begin
        prev_x_d = cur_x;
        prev_y_d = cur_y;
        state_d  = S_IDLE;
        if (!started_q) begin
          // first step: a one-step route reports zero with no check
          if (last_q) begin
            emit = 1'b1;
          end else begin
            started_d = 1'b1;
            err_d     = bad_q;
          end
        end else if (bad_q || err_q) begin
          err_d = 1'b1;
          emit  = last_q;
        end else begin
          leg_start = 1'b1;
          state_d   = S_WAIT;
        end
      end
      S_WAIT: begin
        if (leg_done) begin
          if (sum_ext[rla_pkg::LenW]) begin
            sum_d  = rla_pkg::LenMax;
            clip_d = 1'b1;
          end else begin
            sum_d = sum_ext[rla_pkg::LenW-1:0];
          end
          emit    = last_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // result and route clear on the last step
    if (emit) begin
      rsp_valid_d = 1'b1;
      if (err_d) begin
        rsp_d.route_length     = '0;
        rsp_d.index_error      = 1'b1;
        rsp_d.length_saturated = 1'b0;
      end else begin
        rsp_d.route_length     = sum_d;
        rsp_d.index_error      = 1'b0;
        rsp_d.length_saturated = clip_d;
      end
      started_d = 1'b0;
      err_d     = 1'b0;
      clip_d    = 1'b0;
      sum_d     = '0;
      prev_x_d  = '0;
      prev_y_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      started_q   <= 1'b0;
      err_q       <= 1'b0;
      clip_q      <= 1'b0;
      sum_q       <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      err_q       <= err_d;
      clip_q      <= clip_d;
      sum_q       <= sum_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_valid_i && cfg_ready_o) count_q <= cfg_data_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // checks
`include "route_length_accumulator_macros.svh"

  `RLA_ASSERT_NOW(a_err_zero, rsp_valid_o && rsp_o.index_error, rsp_o.route_length == '0 && !rsp_o.length_saturated, "index error with nonzero length")
  `RLA_ASSERT_NOW(a_sat_max, rsp_valid_o && rsp_o.length_saturated, rsp_o.route_length == rla_pkg::LenMax, "saturated length below maximum")
  `RLA_ASSERT_NEXT(a_leg_busy, leg_start, busy && !rsp_valid_o, "leg started without a busy step")

endmodule
